[src/hjc_pkg.sv]
// Shared constants, types and action codes for the hash join build/probe counter.
// Used by hjc_hash and hash_join_build_probe_counter; depends on nothing.
`timescale 1ns / 1ps
package hjc_pkg;
  localparam int CAPACITY    = 4096;
  localparam int MAX_BUCKETS = 1024;
  localparam int KEY_W       = 64;
  localparam int CFG_W       = 11;
  localparam int TOTAL_W     = 48;
  localparam int LINK_W      = $clog2(CAPACITY + 1);
  localparam int SLOT_W      = $clog2(CAPACITY);
  localparam int BKT_W       = $clog2(MAX_BUCKETS);
  localparam int NB_W        = $clog2(MAX_BUCKETS + 1);
  localparam int MIX_CNT_W   = $clog2(KEY_W);

  localparam logic [KEY_W-1:0] MIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [KEY_W-1:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  localparam logic [1:0] ACT_BUILD = 2'd0;
  localparam logic [1:0] ACT_PROBE = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  typedef struct packed {
    logic             start;
    logic [KEY_W-1:0] key;
    logic [NB_W-1:0]  nbuckets;
  } hjc_hash_req_t;

  typedef struct packed {
    logic             done;
    logic [BKT_W-1:0] bucket;
  } hjc_hash_res_t;
endpackage

[src/hash_join_build_probe_counter.sv]
// Top level of the hash join build/probe counter: bucket head and entry
// memories, control sequencer and result register. Uses hjc_pkg and hjc_hash.
`timescale 1ns / 1ps
// Usage: an input item (in_action, in_key) is taken when in_valid and in_ready
// are high; exactly one result item (out_status, out_match_count,
// out_total_matches) follows on the out_ channel under valid/ready.
// One item is worked on at a time. A build or probe first passes through the
// bucket index unit (three 32x32 partial products per multiply, then one
// remainder bit per cycle). A build then writes its entry and bucket head in
// S_HEAD; a probe reads the head there, then visits each chain entry in S_WALK
// and S_CHECK through the entry memory read port. A build on a full table and
// an unknown action go straight to S_EMIT. A clear item sweeps the 1024 bucket
// heads, one per cycle, then answers. After reset the same sweep runs with
// in_ready low; cfg writes are taken at any time. cfg_wr_data sets the bucket
// count, 1024 at reset. A result waiting on a stalled receiver sits in the
// output register while the next item is accepted; that item holds its result
// until the register frees up.
module hash_join_build_probe_counter import hjc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_action,
  input  logic [KEY_W-1:0]   in_key,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_status,
  output logic [12:0]        out_match_count,
  output logic [TOTAL_W-1:0] out_total_matches,
  input  logic               cfg_wr_en,
  input  logic [CFG_W-1:0]   cfg_wr_data
);
  localparam logic [2:0] S_SWEEP = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_HEAD  = 3'd3;
  localparam logic [2:0] S_WALK  = 3'd4;
  localparam logic [2:0] S_CHECK = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  localparam int ENT_W = KEY_W + LINK_W;

  logic [2:0]         state_r, state_nxt;
  logic [CFG_W-1:0]   cfg_r;
  logic [1:0]         act_r, act_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [BKT_W-1:0]   bkt_r, bkt_nxt;
  logic [BKT_W-1:0]   sweep_r, sweep_nxt;
  logic               clr_item_r, clr_item_nxt;
  logic [LINK_W-1:0]  used_r, used_nxt;
  logic [LINK_W-1:0]  link_r, link_nxt;
  logic [LINK_W-1:0]  steps_r, steps_nxt;
  logic [12:0]        count_r, count_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic               res_status_r, res_status_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_status_r, out_status_nxt;
  logic [12:0]        out_count_r, out_count_nxt;
  logic [TOTAL_W-1:0] out_total_r, out_total_nxt;

  logic [NB_W-1:0]    nbuckets;
  hjc_hash_req_t      hreq;
  hjc_hash_res_t      hres;

  logic [LINK_W-1:0]  head_mem [MAX_BUCKETS];
  logic [LINK_W-1:0]  head_rd;
  logic               head_we;
  logic [BKT_W-1:0]   head_wa;
  logic [LINK_W-1:0]  head_wd;

  logic [ENT_W-1:0]   ent_mem [CAPACITY];
  logic [ENT_W-1:0]   ent_rd;
  logic               ent_we;
  logic [SLOT_W-1:0]  ent_ra;
  logic [LINK_W-1:0]  link_m1;
  logic [TOTAL_W:0]   total_sum;
  logic               full;

  assign nbuckets = (cfg_r == '0) ? NB_W'(1) :
                    ((32'(cfg_r) > MAX_BUCKETS) ? NB_W'(MAX_BUCKETS) : NB_W'(cfg_r));
  assign full      = (used_r == LINK_W'(CAPACITY));
  assign link_m1   = link_r - 1'b1;
  assign ent_ra    = link_m1[SLOT_W-1:0];
  assign total_sum = {1'b0, total_r} + (TOTAL_W + 1)'(count_r);

  assign hreq.key      = key_nxt;
  assign hreq.nbuckets = nbuckets;

  hjc_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (hreq),
    .res   (hres)
  );

  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    key_nxt        = key_r;
    bkt_nxt        = bkt_r;
    sweep_nxt      = sweep_r;
    clr_item_nxt   = clr_item_r;
    used_nxt       = used_r;
    link_nxt       = link_r;
    steps_nxt      = steps_r;
    count_nxt      = count_r;
    total_nxt      = total_r;
    res_status_nxt = res_status_r;
    hreq.start     = 1'b0;
    head_we        = 1'b0;
    head_wa        = bkt_r;
    head_wd        = '0;
    ent_we         = 1'b0;
    unique case (state_r)
      S_SWEEP: begin
        head_we   = 1'b1;
        head_wa   = sweep_r;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == BKT_W'(MAX_BUCKETS - 1)) begin
          state_nxt = clr_item_r ? S_EMIT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          act_nxt        = in_action;
          key_nxt        = in_key;
          count_nxt      = '0;
          res_status_nxt = 1'b0;
          if (in_action == ACT_BUILD && full) begin
            res_status_nxt = 1'b1;
            state_nxt      = S_EMIT;
          end else if (in_action == ACT_BUILD || in_action == ACT_PROBE) begin
            hreq.start = 1'b1;
            state_nxt  = S_HASH;
          end else if (in_action == ACT_CLEAR) begin
            used_nxt     = '0;
            total_nxt    = '0;
            sweep_nxt    = '0;
            clr_item_nxt = 1'b1;
            state_nxt    = S_SWEEP;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_HASH: begin
        if (hres.done) begin
          bkt_nxt   = hres.bucket;
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        if (act_r == ACT_BUILD) begin
          ent_we    = 1'b1;
          head_we   = 1'b1;
          head_wd   = used_r + 1'b1;
          used_nxt  = used_r + 1'b1;
          state_nxt = S_EMIT;
        end else begin
          link_nxt  = head_rd;
          steps_nxt = '0;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (link_r == '0 || steps_r == LINK_W'(CAPACITY)) begin
          total_nxt = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (ent_rd[ENT_W-1:LINK_W] == key_r) begin
          count_nxt = count_r + 1'b1;
        end
        link_nxt  = ent_rd[LINK_W-1:0];
        steps_nxt = steps_r + 1'b1;
        state_nxt = S_WALK;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          clr_item_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_total_nxt  = out_total_r;
    if (state_r == S_EMIT && (!out_valid_r || out_ready)) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_count_nxt  = count_r;
      out_total_nxt  = total_r;
    end
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    head_rd <= head_mem[bkt_nxt];
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[used_r[SLOT_W-1:0]] <= {key_r, head_rd};
    end
    ent_rd <= ent_mem[ent_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      cfg_r       <= CFG_W'(MAX_BUCKETS);
      sweep_r     <= '0;
      clr_item_r  <= 1'b0;
      used_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
      sweep_r     <= sweep_nxt;
      clr_item_r  <= clr_item_nxt;
      used_r      <= used_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
    act_r        <= act_nxt;
    key_r        <= key_nxt;
    bkt_r        <= bkt_nxt;
    link_r       <= link_nxt;
    steps_r      <= steps_nxt;
    count_r      <= count_nxt;
    res_status_r <= res_status_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_total_r  <= out_total_nxt;
  end

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_match_count   = out_count_r;
  assign out_total_matches = out_total_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= LINK_W'(CAPACITY))
    else $error("entry count above capacity");

  a_sweep_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP) |-> (used_r == '0 && total_r == '0))
    else $error("counters not cleared during sweep");

  a_drop_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_match_count == '0))
    else $error("dropped build reports matches");

  a_walk_probe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK || state_r == S_CHECK) |-> (act_r == ACT_PROBE))
    else $error("chain walk outside a probe");
endmodule

[src/hjc_hash.sv]
// Multi-cycle bucket index unit: murmur3 64-bit finalizer on a shared 32x32
// multiplier, then a bit-serial remainder by the bucket count. Uses hjc_pkg.
`timescale 1ns / 1ps
module hjc_hash import hjc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  hjc_hash_req_t req,
  output hjc_hash_res_t res
);
  localparam logic [1:0] H_IDLE = 2'd0;
  localparam logic [1:0] H_MUL1 = 2'd1;
  localparam logic [1:0] H_MUL2 = 2'd2;
  localparam logic [1:0] H_MOD  = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [1:0]           sub_r, sub_nxt;
  logic [MIX_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [KEY_W-1:0]     x_r, x_nxt;
  logic [KEY_W-1:0]     acc_r, acc_nxt;
  logic [NB_W-1:0]      n_r, n_nxt;
  logic [NB_W-1:0]      rem_r, rem_nxt;
  logic                 done_r, done_nxt;
  logic [KEY_W-1:0]     cst;
  logic [31:0]          op_a, op_b;
  logic [63:0]          prod;
  logic [KEY_W-1:0]     sum;
  logic [NB_W:0]        trial;

  assign cst  = (state_r == H_MUL1) ? MIX_C1 : MIX_C2;
  assign op_a = (sub_r == 2'd2) ? x_r[63:32] : x_r[31:0];
  assign op_b = (sub_r == 2'd1) ? cst[63:32] : cst[31:0];
  assign prod = op_a * op_b;
  assign sum  = acc_r + {prod[31:0], 32'b0};
  assign trial = {rem_r, x_r[KEY_W-1]};

  always_comb begin
    state_nxt = state_r;
    sub_nxt   = sub_r;
    cnt_nxt   = cnt_r;
    x_nxt     = x_r;
    acc_nxt   = acc_r;
    n_nxt     = n_r;
    rem_nxt   = rem_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      H_IDLE: begin
        if (req.start) begin
          x_nxt     = req.key ^ (req.key >> 33);
          n_nxt     = req.nbuckets;
          sub_nxt   = 2'd0;
          state_nxt = H_MUL1;
        end
      end
      H_MUL1, H_MUL2: begin
        if (sub_r == 2'd0) begin
          acc_nxt = prod;
          sub_nxt = 2'd1;
        end else if (sub_r == 2'd1) begin
          acc_nxt = sum;
          sub_nxt = 2'd2;
        end else begin
          x_nxt   = sum ^ (sum >> 33);
          sub_nxt = 2'd0;
          if (state_r == H_MUL1) begin
            state_nxt = H_MUL2;
          end else begin
            rem_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = H_MOD;
          end
        end
      end
      H_MOD: begin
        if (trial >= {1'b0, n_r}) begin
          rem_nxt = NB_W'(trial - {1'b0, n_r});
        end else begin
          rem_nxt = NB_W'(trial);
        end
        x_nxt   = x_r << 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == MIX_CNT_W'(KEY_W - 1)) begin
          done_nxt  = 1'b1;
          state_nxt = H_IDLE;
        end
      end
      default: state_nxt = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      done_r  <= 1'b0;
      sub_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      sub_r   <= sub_nxt;
      cnt_r   <= cnt_nxt;
    end
    x_r   <= x_nxt;
    acc_r <= acc_nxt;
    n_r   <= n_nxt;
    rem_r <= rem_nxt;
  end

  assign res.done   = done_r;
  assign res.bucket = rem_r[BKT_W-1:0];
endmodule
